@@ design/assert_macros.svh @@
// assertion macros used by the top-level core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define A_CHECK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define A_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/alc_pkg.sv @@
// types, constants and helper functions of the ambient light dimmer control
package alc_pkg;

	localparam logic [15:0] ErrorCode   = 16'd54612;
	localparam logic [24:0] Recip100    = 25'd21474837;
	localparam logic [11:0] Recip10     = 12'd3277;
	localparam logic [17:0] StepSatDist = 18'd2560;
	localparam logic [21:0] PctRecip    = 22'd3289700;
	localparam logic [1:0]  RefreshLen  = 2'd3;
	localparam int          NumLanes    = 4;

	typedef enum logic [2:0] {
		RegTrigLow  = 3'd0,
		RegTrigHigh = 3'd1,
		RegTgtLow   = 3'd2,
		RegTgtHigh  = 3'd3,
		RegMaxStep  = 3'd4,
		RegStartDuty = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [6:0] trig_lo;
		logic [7:0] trig_hi;
		logic [6:0] tgt_lo;
		logic [7:0] tgt_hi;
		logic [7:0] max_step;
		logic [7:0] start_duty;
	} cfg_t;

	typedef struct packed {
		logic [17:0] trig_lo;
		logic [17:0] trig_hi;
		logic [17:0] tgt_lo;
		logic [17:0] tgt_hi;
	} edges_t;

	typedef struct packed {
		logic [15:0] raw_mean;
		logic        err;
		logic [1:0]  bad;
		logic        toggle;
		logic        window;
	} mean_item_t;

	typedef struct packed {
		logic [7:0]  duty;
		logic [15:0] mean;
		logic        err;
		logic [1:0]  bad;
		logic        adj;
		logic        lamp;
	} res_t;

	// floor(x / 100) for any 24-bit x
	function automatic logic [17:0] div100(input logic [23:0] x);
		logic [48:0] p;
		p = {25'd0, x} * {24'd0, Recip100};
		return p[48:31];
	endfunction

endpackage

@@ design/alc_lane.sv @@
// one sensor lane: error code check and first pipeline register
module alc_lane import alc_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [15:0] lux,
	output logic [15:0] lux_s1,
	output logic        err_s1
);

	always_ff @(posedge clk) begin
		if (en) begin
			lux_s1 <= lux;
			err_s1 <= (lux == ErrorCode);
		end
	end

endmodule

@@ design/alc_edge.sv @@
// band edges of a level: level * percent / 100 for the four band edges, two stages
module alc_edge import alc_pkg::*; (
	input  logic        clk,
	input  logic        ld_prod,
	input  logic        ld_quot,
	input  logic [15:0] value,
	input  cfg_t        cfg,
	output edges_t      edges
);

	logic [23:0] trig_lo_s1, trig_hi_s1, tgt_lo_s1, tgt_hi_s1;

	always_ff @(posedge clk) begin
		if (ld_prod) begin
			trig_lo_s1 <= {8'd0, value} * {17'd0, cfg.trig_lo};
			trig_hi_s1 <= {8'd0, value} * {16'd0, cfg.trig_hi};
			tgt_lo_s1  <= {8'd0, value} * {17'd0, cfg.tgt_lo};
			tgt_hi_s1  <= {8'd0, value} * {16'd0, cfg.tgt_hi};
		end
	end

	always_ff @(posedge clk) begin
		if (ld_quot) begin
			edges.trig_lo <= div100(trig_lo_s1);
			edges.trig_hi <= div100(trig_hi_s1);
			edges.tgt_lo  <= div100(tgt_lo_s1);
			edges.tgt_hi  <= div100(tgt_hi_s1);
		end
	end

endmodule

@@ design/alc_ctrl.sv @@
// control state: lamp, base level, adjust mode and duty stepping
module alc_ctrl import alc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  mean_item_t  item,
	input  edges_t      cand,
	input  cfg_t        cfg,
	input  logic        ld_ref,
	input  edges_t      ref_edges,
	output res_t        res,
	output logic [15:0] base
);

	logic        lamp_q, init_q, adj_q, seen_q;
	logic [15:0] mean_q, base_q;
	logic [7:0]  duty_q;
	edges_t      edges_q;

	logic        lamp_n, init_n, adj_n, seen_n;
	logic [15:0] mean_n, base_n;
	logic [7:0]  duty_n;
	edges_t      edges_n;

	// step = clamp(gap / 10, 1, max_step); large gaps saturate directly
	function automatic logic [7:0] clamp_step(input logic [17:0] gap, input logic [7:0] mx);
		logic [23:0] p;
		logic [7:0]  q;
		p = {12'd0, gap[11:0]} * {12'd0, Recip10};
		q = p[22:15];
		if (gap >= StepSatDist)
			return mx;
		if (q > mx)
			return mx;
		if (q == 8'd0)
			return 8'd1;
		return q;
	endfunction

	always_comb begin
		logic [17:0] mean_x;
		logic [17:0] gap;
		logic [7:0]  step;
		logic [8:0]  sum9;
		logic        below, above;
		lamp_n  = lamp_q ^ item.toggle;
		mean_n  = item.err ? mean_q : item.raw_mean;
		seen_n  = seen_q | ~item.err;
		init_n  = init_q;
		adj_n   = adj_q;
		duty_n  = duty_q;
		base_n  = base_q;
		edges_n = edges_q;
		mean_x  = '0;
		gap     = '0;
		step    = '0;
		sum9    = '0;
		below   = 1'b0;
		above   = 1'b0;
		if (lamp_n && item.window) begin
			if (!init_q) begin
				duty_n  = cfg.start_duty;
				mean_n  = item.raw_mean;
				base_n  = item.raw_mean;
				edges_n = cand;
				init_n  = 1'b1;
			end
			if (seen_n) begin
				mean_x = {2'b00, mean_n};
				if (mean_x < edges_n.trig_lo || mean_x > edges_n.trig_hi)
					adj_n = 1'b1;
				below = mean_x < edges_n.tgt_lo;
				above = mean_x > edges_n.tgt_hi;
				gap   = below ? (edges_n.tgt_lo - mean_x) : (mean_x - edges_n.tgt_hi);
				step  = clamp_step(gap, cfg.max_step);
				if (adj_n) begin
					if (below) begin
						sum9   = {1'b0, duty_n} + {1'b0, step};
						duty_n = sum9[8] ? 8'hFF : sum9[7:0];
					end else if (above) begin
						duty_n = (duty_n >= step) ? (duty_n - step) : 8'd0;
					end else begin
						adj_n = 1'b0;
					end
				end
			end
		end else begin
			lamp_n  = 1'b0;
			duty_n  = 8'd0;
			base_n  = 16'd0;
			edges_n = '0;
			init_n  = 1'b0;
			adj_n   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lamp_q  <= 1'b0;
			init_q  <= 1'b0;
			adj_q   <= 1'b0;
			seen_q  <= 1'b0;
			mean_q  <= 16'd0;
			base_q  <= 16'd0;
			duty_q  <= 8'd0;
			edges_q <= '0;
		end else if (fire) begin
			lamp_q  <= lamp_n;
			init_q  <= init_n;
			adj_q   <= adj_n;
			seen_q  <= seen_n;
			mean_q  <= mean_n;
			base_q  <= base_n;
			duty_q  <= duty_n;
			edges_q <= edges_n;
		end else if (ld_ref) begin
			// stored edges rebuilt from the base after any configuration register write
			edges_q <= ref_edges;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res.duty <= duty_n;
			res.mean <= mean_n;
			res.err  <= item.err;
			res.bad  <= item.bad;
			res.adj  <= adj_n;
			res.lamp <= lamp_n;
		end
	end

	assign base = base_q;

endmodule

@@ design/ambient_light_dimmer_control_core.sv @@
// ambient light dimmer control: top level with lanes, merge, edge units and output stage
// Input stream: one transaction carries four lux readings plus the lamp toggle and
// window flags. Output stream: one transaction per input with duty, percent, mean,
// sensor error status, adjusting and lamp state. Config channel: cfg_index selects
// one of six band, step and start registers, cfg_data holds the value; always ready.
// Items pass the lane, merge, control and output registers. One item is taken per
// cycle, stalls and edge rebuilds apart, since the band edges of the stored base sit
// in registers and the control update per item is a single compare, divide-by-ten and add stage.
// After each configuration write the input stays not ready while the stored band
// edges are rebuilt from the base by the edge unit.
// Reset clears the lamp, base, duty, adjust state and all valid flags, and loads the
// register defaults. When the receiver stalls, each stage holds its item and the
// bubbles ahead of it fill; input ready then drops once every stage is occupied.
`include "assert_macros.svh"

module ambient_light_dimmer_control_core import alc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// lux_a, lux_b, lux_c, lux_d, toggle_lamp, in_window, zero fill
	input  logic [71:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// duty, percent, mean_lux, sensor_error, bad_sensor, adjusting, lamp_active, zero fill
	output logic [39:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	cfg_t        cfg_q;
	logic [1:0]  refresh_cnt_q;
	logic        cfg_fire;

	logic        v1_s1, v2_s2, v3_s3, v4_s4, v5_s5, v6_s6;
	logic        r1, r2, r3, r4, r5, r6;
	logic        s_fire, ld2, ld3, ld4, ld5, ld6;

	logic [NumLanes-1:0][15:0] lux_s1;
	logic [NumLanes-1:0]       err_s1;
	logic                      toggle_s1, window_s1;

	mean_item_t  merged, m_s2, m_s3, m_s4;
	logic [17:0] lux_sum;
	edges_t      cand_edges, base_edges;
	res_t        res_s5, out_s6;
	logic [6:0]  pct_s6;
	logic [29:0] pct_prod;
	logic [15:0] base_lvl;

	// configuration
	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid & cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trig_lo    <= 7'd92;
			cfg_q.trig_hi    <= 8'd108;
			cfg_q.tgt_lo     <= 7'd97;
			cfg_q.tgt_hi     <= 8'd103;
			cfg_q.max_step   <= 8'd10;
			cfg_q.start_duty <= 8'd125;
			refresh_cnt_q    <= 2'd0;
		end else begin
			if (cfg_fire) begin
				case (cfg_idx_t'(cfg_index))
					RegTrigLow:   cfg_q.trig_lo    <= cfg_data[6:0];
					RegTrigHigh:  cfg_q.trig_hi    <= cfg_data;
					RegTgtLow:    cfg_q.tgt_lo     <= cfg_data[6:0];
					RegTgtHigh:   cfg_q.tgt_hi     <= cfg_data;
					RegMaxStep:   cfg_q.max_step   <= cfg_data;
					RegStartDuty: cfg_q.start_duty <= cfg_data;
					default: ;
				endcase
			end
			if (cfg_fire)
				refresh_cnt_q <= RefreshLen;
			else if (refresh_cnt_q != 2'd0)
				refresh_cnt_q <= refresh_cnt_q - 2'd1;
		end
	end

	// stage handshake: a stage advances when empty or when the next one advances
	assign r6 = ~v6_s6 | m_axis_tready;
	assign r5 = ~v5_s5 | r6;
	assign r4 = ~v4_s4 | r5;
	assign r3 = ~v3_s3 | r4;
	assign r2 = ~v2_s2 | r3;
	assign r1 = ~v1_s1 | r2;

	assign s_axis_tready = r1 & (refresh_cnt_q == 2'd0);
	assign s_fire = s_axis_tvalid & s_axis_tready;
	assign ld2 = v1_s1 & r2;
	assign ld3 = v2_s2 & r3;
	assign ld4 = v3_s3 & r4;
	assign ld5 = v4_s4 & r5;
	assign ld6 = v5_s5 & r6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
			v5_s5 <= 1'b0;
			v6_s6 <= 1'b0;
		end else begin
			if (r1) v1_s1 <= s_fire;
			if (r2) v2_s2 <= v1_s1;
			if (r3) v3_s3 <= v2_s2;
			if (r4) v4_s4 <= v3_s3;
			if (r5) v5_s5 <= v4_s4;
			if (r6) v6_s6 <= v5_s5;
		end
	end

	// sensor lanes
	for (genvar i = 0; i < NumLanes; i++) begin : g_lane
		alc_lane u_lane (
			.clk    (clk),
			.en     (s_fire),
			.lux    (s_axis_tdata[16*i +: 16]),
			.lux_s1 (lux_s1[i]),
			.err_s1 (err_s1[i])
		);
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			toggle_s1 <= s_axis_tdata[64];
			window_s1 <= s_axis_tdata[65];
		end
	end

	// merge: mean of the lanes and first failing lane
	always_comb begin
		lux_sum = {2'b00, lux_s1[0]} + {2'b00, lux_s1[1]}
			+ {2'b00, lux_s1[2]} + {2'b00, lux_s1[3]};
		merged.raw_mean = lux_sum[17:2];
		merged.err      = |err_s1;
		merged.toggle   = toggle_s1;
		merged.window   = window_s1;
		if (err_s1[0])
			merged.bad = 2'd0;
		else if (err_s1[1])
			merged.bad = 2'd1;
		else if (err_s1[2])
			merged.bad = 2'd2;
		else if (err_s1[3])
			merged.bad = 2'd3;
		else
			merged.bad = 2'd0;
	end

	always_ff @(posedge clk) begin
		if (ld2) m_s2 <= merged;
		if (ld3) m_s3 <= m_s2;
		if (ld4) m_s4 <= m_s3;
	end

	// candidate edges in case this item starts control
	alc_edge u_edge_item (
		.clk     (clk),
		.ld_prod (ld3),
		.ld_quot (ld4),
		.value   (m_s2.raw_mean),
		.cfg     (cfg_q),
		.edges   (cand_edges)
	);

	// edges of the stored base, used after a configuration write
	alc_edge u_edge_base (
		.clk     (clk),
		.ld_prod (1'b1),
		.ld_quot (1'b1),
		.value   (base_lvl),
		.cfg     (cfg_q),
		.edges   (base_edges)
	);

	alc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (ld5),
		.item      (m_s4),
		.cand      (cand_edges),
		.cfg       (cfg_q),
		.ld_ref    (refresh_cnt_q == 2'd1),
		.ref_edges (base_edges),
		.res       (res_s5),
		.base      (base_lvl)
	);

	// output stage: percent = floor(duty * 100 / 255)
	assign pct_prod = {22'd0, res_s5.duty} * {8'd0, PctRecip};

	always_ff @(posedge clk) begin
		if (ld6) begin
			out_s6 <= res_s5;
			pct_s6 <= pct_prod[29:23];
		end
	end

	assign m_axis_tvalid = v6_s6;
	assign m_axis_tdata  = {4'd0, out_s6.lamp, out_s6.adj, out_s6.bad, out_s6.err,
		out_s6.mean, pct_s6, out_s6.duty};

	`A_CHECK(a_off_dark, clk, arst_n, !(v6_s6 && !out_s6.lamp) || (out_s6.duty == 8'd0), "duty not zero with lamp off")
	`A_CHECK(a_adj_lamp, clk, arst_n, !(v6_s6 && out_s6.adj) || out_s6.lamp, "adjusting while lamp off")
	`A_CHECK(a_pct_range, clk, arst_n, !v6_s6 || (pct_s6 <= 7'd100), "percent above one hundred")
	`A_NEXT(a_refresh_hold, clk, arst_n, cfg_fire, !s_axis_tready, "input ready during edge rebuild")

endmodule
